// ===== rtl/core/tcaf_pkg.sv =====
// Shared types and constants of the Tustin complementary angle filter.
// Used by tcaf_div, tustin_complementary_angle_filter and its testbench; depends on nothing.

package tcaf_pkg;

   // Fixed-point formats
   localparam int FRAC_BITS     = 16;            // fraction bits of angles, rates, T, tau
   localparam int KBITS         = 30;            // fraction bits of the coefficients
   localparam int CHANNEL_COUNT = 2;

   // Configuration register widths and indexes
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_CONSTANT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_FIRST  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_SECOND = 2'd3;

   localparam logic [15:0]        SAMPLE_PERIOD_RESET = 16'd655;
   localparam logic [23:0]        TIME_CONSTANT_RESET = 24'd35383;
   localparam logic signed [23:0] OFFSET_FIRST_RESET  = 24'sd55050;
   localparam logic signed [23:0] OFFSET_SECOND_RESET = 24'sd48497;

   // Coefficient divider: 58-bit dividend, 26-bit divisor, 32-bit quotient
   localparam int DIV_N_W = 58;
   localparam int DIV_D_W = 26;
   localparam int DIV_Q_W = 32;
   localparam int DIV_C_W = $clog2(DIV_Q_W);

   // Datapath widths
   localparam int COEF_W  = 32;                  // signed coefficient
   localparam int MOP_W   = 33;                  // signed multiplier operand
   localparam int MUL_W   = 2 * MOP_W;           // signed product
   localparam int SUM_W   = 42;                  // acc + prev_acc + tau term
   localparam int SPLIT   = 22;                  // low part of the sum in the split product
   localparam int HI_W    = SUM_W - SPLIT;
   localparam int WIDE_W  = 74;                  // accumulated k2 * sum
   localparam int T1_W    = 36;                  // rounded k1 * prev_out
   localparam int T2_W    = 44;                  // rounded k2 * sum
   localparam int RES_W   = 45;                  // unsaturated result

   localparam logic signed [MUL_W-1:0]  TG_HALF   = MUL_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [MUL_W-1:0]  K_HALF    = MUL_W'(1) << (KBITS - 1);
   localparam logic signed [WIDE_W-1:0] K_HALF_W  = WIDE_W'(1) << (KBITS - 1);
   localparam logic signed [COEF_W-1:0] K_ONE     = COEF_W'(1) << KBITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV_K1,
      ST_DIV_K2,
      ST_MUL_TG,
      ST_MUL_K1,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACC_HI,
      ST_ROUND,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/core/tcaf_div.sv =====
// Restoring divider, one quotient bit per cycle, for the filter coefficients.
// Depends on tcaf_pkg for its widths; the quotient must be known to fit DIV_Q_W bits.

module tcaf_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [tcaf_pkg::DIV_N_W-1:0]     dividend,
   input  logic [tcaf_pkg::DIV_D_W-1:0]     divisor,
   output logic                             done,
   output logic [tcaf_pkg::DIV_Q_W-1:0]     quotient
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [tcaf_pkg::DIV_C_W-1:0]    count_ff, count_in;
   logic [tcaf_pkg::DIV_D_W-1:0]    rem_ff, rem_in;
   logic [tcaf_pkg::DIV_Q_W-1:0]    quo_ff, quo_in;
   logic [tcaf_pkg::DIV_D_W:0]      trial;
   logic [tcaf_pkg::DIV_D_W+1:0]    diff;

   // The upper dividend bits start below the divisor, so the quotient fits
   // and the partial remainder never needs more than the divisor's width.
   assign trial = {rem_ff, quo_ff[tcaf_pkg::DIV_Q_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, divisor};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '1;
         rem_in   = dividend[tcaf_pkg::DIV_N_W-1:tcaf_pkg::DIV_Q_W];
         quo_in   = dividend[tcaf_pkg::DIV_Q_W-1:0];
      end else if (busy_ff) begin
         if (diff[tcaf_pkg::DIV_D_W+1]) begin
            rem_in = trial[tcaf_pkg::DIV_D_W-1:0];
         end else begin
            rem_in = diff[tcaf_pkg::DIV_D_W-1:0];
         end
         quo_in   = {quo_ff[tcaf_pkg::DIV_Q_W-2:0], ~diff[tcaf_pkg::DIV_D_W+1]};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/tustin_complementary_angle_filter.sv =====
// Tustin first-order complementary angle filter for two sensor channels.
// Depends on tcaf_pkg and instantiates the coefficient divider tcaf_div.

// An item is taken only while the block is idle. It runs from ST_PREP through the
// multiply states, ST_ACC_HI and ST_ROUND to ST_FINISH, which writes the output
// register and waits while a stalled result beat still holds it. A single 33 by 33 bit
// multiplier is reused for the tau term, the k1 term and the two halves of the k2 term,
// with the accumulate, rounding and saturation steps after. After reset and after any
// configuration write, the next item also recomputes k1 and k2 with two 32-step
// divisions on the bit-serial divider, unless T and tau are both zero. The input side
// is free again while a finished result still waits in the output register.

module tustin_complementary_angle_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_channel,
   input  logic signed [31:0]                req_accel_angle,
   input  logic signed [31:0]                req_gyro_rate,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_filtered_angle,
   output logic                              rsp_saturated,
   input  logic                              csr_write,
   input  logic [tcaf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tcaf_pkg::CSR_DATA_W-1:0]   csr_data
);

   // Configuration
   logic [15:0]        sample_period_ff;
   logic [23:0]        time_constant_ff;
   logic signed [23:0] offset_first_ff;
   logic signed [23:0] offset_second_ff;
   logic               coef_stale_ff, coef_stale_in;

   // Sequencer
   tcaf_pkg::state_type state_ff, state_in;

   // Captured beat and working registers
   logic                                   chan_ff;
   logic signed [31:0]                     accel_in_ff;
   logic signed [31:0]                     gyro_in_ff;
   logic signed [31:0]                     acc_c_ff, acc_c_in;
   logic signed [31:0]                     pacc_ff, pacc_in;
   logic signed [31:0]                     pout_ff, pout_in;
   logic signed [tcaf_pkg::MOP_W-1:0]      sg_ff, sg_in;
   logic signed [tcaf_pkg::COEF_W-1:0]     k1_ff, k1_in;
   logic signed [tcaf_pkg::COEF_W-1:0]     k2_ff, k2_in;
   logic signed [tcaf_pkg::MUL_W-1:0]      prod_ff;
   logic signed [tcaf_pkg::SUM_W-1:0]      sum_ff;
   logic signed [tcaf_pkg::T1_W-1:0]       term1_ff;
   logic signed [tcaf_pkg::WIDE_W-1:0]     wide_ff, wide_in;
   logic signed [tcaf_pkg::T2_W-1:0]       term2_ff;

   // Per-channel history
   logic signed [31:0] prev_accel_ff  [tcaf_pkg::CHANNEL_COUNT];
   logic signed [31:0] prev_gyro_ff   [tcaf_pkg::CHANNEL_COUNT];
   logic signed [31:0] prev_output_ff [tcaf_pkg::CHANNEL_COUNT];
   logic [tcaf_pkg::CHANNEL_COUNT-1:0] primed_ff;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_angle_ff;
   logic               rsp_sat_ff;

   // Combinational helpers
   logic                               accept;
   logic                               finish;
   logic signed [32:0]                 acc_wide;
   logic signed [31:0]                 acc_sat;
   logic [tcaf_pkg::DIV_D_W-1:0]       denom;
   logic [tcaf_pkg::DIV_D_W-2:0]       denom_half;
   logic [27:0]                        num1_scale;
   logic [tcaf_pkg::DIV_N_W-1:0]       num1;
   logic [tcaf_pkg::DIV_N_W-1:0]       num2;
   logic                               div_start;
   logic                               div_done;
   logic [tcaf_pkg::DIV_Q_W-1:0]       div_quo;
   logic signed [tcaf_pkg::MOP_W-1:0]  mul_a;
   logic signed [tcaf_pkg::MOP_W-1:0]  mul_b;
   logic signed [tcaf_pkg::MUL_W-1:0]  tg_round;
   logic signed [tcaf_pkg::MUL_W-1:0]  t1_round;
   logic signed [tcaf_pkg::WIDE_W-1:0] prod_ext;
   logic signed [tcaf_pkg::WIDE_W-1:0] t2_round;
   logic signed [tcaf_pkg::SUM_W-1:0]  sum_in;
   logic signed [tcaf_pkg::RES_W-1:0]  res_raw;
   logic signed [31:0]                 res_sat;
   logic                               res_clip;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = (state_ff != tcaf_pkg::ST_IDLE);
   assign finish    = (state_ff == tcaf_pkg::ST_FINISH) & (~rsp_valid_ff | ~rsp_stall);

   // Corrected accel angle: channel zero adds its offset, the other subtracts its own.
   always_comb begin
      if (chan_ff == 1'b0) begin
         acc_wide = 33'(accel_in_ff) + 33'(offset_first_ff);
      end else begin
         acc_wide = 33'(accel_in_ff) - 33'(offset_second_ff);
      end
      if (acc_wide[32] != acc_wide[31]) begin
         acc_sat = acc_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         acc_sat = acc_wide[31:0];
      end
   end

   // Coefficient dividends. k1 is found as an unsigned quotient offset by 2^31,
   // which keeps the dividend positive; the top quotient bit is then flipped back.
   assign denom      = {1'b0, time_constant_ff, 1'b0} + {10'd0, sample_period_ff};
   assign denom_half = denom[tcaf_pkg::DIV_D_W-1:1];
   assign num1_scale = {1'b0, denom, 1'b0} + {2'b00, denom} - {11'd0, sample_period_ff, 1'b0};
   assign num1       = {num1_scale, 30'd0} + {33'd0, denom_half};
   assign num2       = {12'd0, sample_period_ff, 30'd0} + {33'd0, denom_half};

   assign div_start = ((state_ff == tcaf_pkg::ST_PREP) && coef_stale_ff && (denom != '0))
                    || ((state_ff == tcaf_pkg::ST_DIV_K1) && div_done);

   tcaf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ((state_ff == tcaf_pkg::ST_PREP) ? num1 : num2),
      .divisor  (denom),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Operand selection of the shared multiplier
   always_comb begin
      case (state_ff)
         tcaf_pkg::ST_MUL_TG: begin
            mul_a = $signed({9'd0, time_constant_ff});
            mul_b = sg_ff;
         end
         tcaf_pkg::ST_MUL_K1: begin
            mul_a = 33'(k1_ff);
            mul_b = 33'(pout_ff);
         end
         tcaf_pkg::ST_MUL_LO: begin
            mul_a = 33'(k2_ff);
            mul_b = $signed({{(tcaf_pkg::MOP_W - tcaf_pkg::SPLIT){1'b0}},
                             sum_ff[tcaf_pkg::SPLIT-1:0]});
         end
         tcaf_pkg::ST_MUL_HI: begin
            mul_a = 33'(k2_ff);
            mul_b = 33'($signed(sum_ff[tcaf_pkg::SUM_W-1:tcaf_pkg::SPLIT]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign tg_round = (prod_ff + tcaf_pkg::TG_HALF) >>> tcaf_pkg::FRAC_BITS;
   assign t1_round = (prod_ff + tcaf_pkg::K_HALF) >>> tcaf_pkg::KBITS;
   assign prod_ext = tcaf_pkg::WIDE_W'(prod_ff);
   assign t2_round = (wide_ff + tcaf_pkg::K_HALF_W) >>> tcaf_pkg::KBITS;
   assign sum_in   = tcaf_pkg::SUM_W'(acc_c_ff) + tcaf_pkg::SUM_W'(pacc_ff)
                   + $signed(tg_round[tcaf_pkg::SUM_W-1:0]);

   assign res_raw = tcaf_pkg::RES_W'(term1_ff) + tcaf_pkg::RES_W'(term2_ff);
   always_comb begin
      if (res_raw > tcaf_pkg::RES_W'(32'sh7FFF_FFFF)) begin
         res_sat  = 32'sh7FFF_FFFF;
         res_clip = 1'b1;
      end else if (res_raw < tcaf_pkg::RES_W'(32'sh8000_0000)) begin
         res_sat  = 32'sh8000_0000;
         res_clip = 1'b1;
      end else begin
         res_sat  = res_raw[31:0];
         res_clip = 1'b0;
      end
   end

   // Sequencer: next state and working-register updates
   always_comb begin
      state_in      = state_ff;
      coef_stale_in = coef_stale_ff;
      acc_c_in      = acc_c_ff;
      pacc_in       = pacc_ff;
      pout_in       = pout_ff;
      sg_in         = sg_ff;
      k1_in         = k1_ff;
      k2_in         = k2_ff;
      wide_in       = wide_ff;
      case (state_ff)
         tcaf_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = tcaf_pkg::ST_PREP;
            end
         end
         tcaf_pkg::ST_PREP: begin
            // A channel's first beat uses its own values as history.
            acc_c_in = acc_sat;
            if (primed_ff[chan_ff]) begin
               pacc_in = prev_accel_ff[chan_ff];
               pout_in = prev_output_ff[chan_ff];
               sg_in   = 33'(gyro_in_ff) + 33'(prev_gyro_ff[chan_ff]);
            end else begin
               pacc_in = acc_sat;
               pout_in = acc_sat;
               sg_in   = 33'(gyro_in_ff) + 33'(gyro_in_ff);
            end
            if (!coef_stale_ff) begin
               state_in = tcaf_pkg::ST_MUL_TG;
            end else if (denom == '0) begin
               // Both T and tau zero: the output simply holds.
               k1_in         = tcaf_pkg::K_ONE;
               k2_in         = '0;
               coef_stale_in = 1'b0;
               state_in      = tcaf_pkg::ST_MUL_TG;
            end else begin
               state_in = tcaf_pkg::ST_DIV_K1;
            end
         end
         tcaf_pkg::ST_DIV_K1: begin
            if (div_done) begin
               k1_in    = $signed({~div_quo[tcaf_pkg::DIV_Q_W-1],
                                   div_quo[tcaf_pkg::DIV_Q_W-2:0]});
               state_in = tcaf_pkg::ST_DIV_K2;
            end
         end
         tcaf_pkg::ST_DIV_K2: begin
            if (div_done) begin
               k2_in         = $signed(div_quo);
               coef_stale_in = 1'b0;
               state_in      = tcaf_pkg::ST_MUL_TG;
            end
         end
         tcaf_pkg::ST_MUL_TG: begin
            state_in = tcaf_pkg::ST_MUL_K1;
         end
         tcaf_pkg::ST_MUL_K1: begin
            state_in = tcaf_pkg::ST_MUL_LO;
         end
         tcaf_pkg::ST_MUL_LO: begin
            state_in = tcaf_pkg::ST_MUL_HI;
         end
         tcaf_pkg::ST_MUL_HI: begin
            wide_in  = prod_ext;
            state_in = tcaf_pkg::ST_ACC_HI;
         end
         tcaf_pkg::ST_ACC_HI: begin
            wide_in  = wide_ff + (prod_ext <<< tcaf_pkg::SPLIT);
            state_in = tcaf_pkg::ST_ROUND;
         end
         tcaf_pkg::ST_ROUND: begin
            state_in = tcaf_pkg::ST_FINISH;
         end
         tcaf_pkg::ST_FINISH: begin
            if (finish) begin
               state_in = tcaf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcaf_pkg::ST_IDLE;
         end
      endcase
      // Any register write makes the coefficients stale.
      if (csr_write) begin
         coef_stale_in = 1'b1;
      end
   end

   assign rsp_valid_in = finish | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= tcaf_pkg::ST_IDLE;
         coef_stale_ff    <= 1'b1;
         rsp_valid_ff     <= 1'b0;
         primed_ff        <= '0;
         sample_period_ff <= tcaf_pkg::SAMPLE_PERIOD_RESET;
         time_constant_ff <= tcaf_pkg::TIME_CONSTANT_RESET;
         offset_first_ff  <= tcaf_pkg::OFFSET_FIRST_RESET;
         offset_second_ff <= tcaf_pkg::OFFSET_SECOND_RESET;
      end else begin
         state_ff      <= state_in;
         coef_stale_ff <= coef_stale_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (finish) begin
            primed_ff[chan_ff] <= 1'b1;
         end
         if (csr_write) begin
            case (csr_index)
               tcaf_pkg::CSR_SAMPLE_PERIOD: sample_period_ff <= csr_data[15:0];
               tcaf_pkg::CSR_TIME_CONSTANT: time_constant_ff <= csr_data;
               tcaf_pkg::CSR_OFFSET_FIRST:  offset_first_ff  <= $signed(csr_data);
               tcaf_pkg::CSR_OFFSET_SECOND: offset_second_ff <= $signed(csr_data);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         chan_ff     <= req_channel;
         accel_in_ff <= req_accel_angle;
         gyro_in_ff  <= req_gyro_rate;
      end
      acc_c_ff <= acc_c_in;
      pacc_ff  <= pacc_in;
      pout_ff  <= pout_in;
      sg_ff    <= sg_in;
      k1_ff    <= k1_in;
      k2_ff    <= k2_in;
      wide_ff  <= wide_in;
      prod_ff  <= mul_a * mul_b;
      if (state_ff == tcaf_pkg::ST_MUL_K1) begin
         sum_ff <= sum_in;
      end
      if (state_ff == tcaf_pkg::ST_MUL_LO) begin
         term1_ff <= t1_round[tcaf_pkg::T1_W-1:0];
      end
      if (state_ff == tcaf_pkg::ST_ROUND) begin
         term2_ff <= t2_round[tcaf_pkg::T2_W-1:0];
      end
      if (finish) begin
         prev_accel_ff[chan_ff]  <= acc_c_ff;
         prev_gyro_ff[chan_ff]   <= gyro_in_ff;
         prev_output_ff[chan_ff] <= res_sat;
         rsp_angle_ff            <= res_sat;
         rsp_sat_ff              <= res_clip;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_angle = rsp_angle_ff;
   assign rsp_saturated      = rsp_sat_ff;

endmodule

// ===== tb/sv/tb_tustin_complementary_angle_filter.sv =====
// Self-checking testbench for the Tustin complementary angle filter: a predictor class
// tracks both channels and the registers, and checks every result beat in order.
// Depends on tcaf_pkg and tustin_complementary_angle_filter.

module tb_tustin_complementary_angle_filter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_MARGIN     = 50;
   localparam int RANDOM_PER_PHASE = 190;

   localparam logic signed [31:0] WORD_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] WORD_MIN  = 32'sh8000_0000;
   localparam longint             COEF_ONE  = 64'sd1 <<< tcaf_pkg::KBITS;
   localparam longint             TERM_HALF = 64'sd1 <<< (tcaf_pkg::FRAC_BITS - 1);

   typedef struct packed {
      logic signed [31:0] angle;
      logic               saturated;
   } angle_beat_type;

   typedef enum int {FLOW_FREE, FLOW_RANDOM, FLOW_PERIODIC, FLOW_HEAVY} flow_mode_type;

   class angle_filter_predictor;
      logic [15:0]        sample_period;
      logic [23:0]        time_constant;
      logic signed [23:0] offset_first;
      logic signed [23:0] offset_second;
      longint             last_accel [tcaf_pkg::CHANNEL_COUNT];
      longint             last_gyro  [tcaf_pkg::CHANNEL_COUNT];
      longint             last_angle [tcaf_pkg::CHANNEL_COUNT];
      bit                 primed     [tcaf_pkg::CHANNEL_COUNT];
      angle_beat_type     expected_angles[$];
      int                 mismatch_count;

      function new();
         sample_period = tcaf_pkg::SAMPLE_PERIOD_RESET;
         time_constant = tcaf_pkg::TIME_CONSTANT_RESET;
         offset_first  = tcaf_pkg::OFFSET_FIRST_RESET;
         offset_second = tcaf_pkg::OFFSET_SECOND_RESET;
         for (int c = 0; c < tcaf_pkg::CHANNEL_COUNT; c++) begin
            last_accel[c] = 0;
            last_gyro[c]  = 0;
            last_angle[c] = 0;
            primed[c]     = 1'b0;
         end
         mismatch_count = 0;
      endfunction

      function void set_register(logic [tcaf_pkg::CSR_INDEX_W-1:0] index,
                                 logic [tcaf_pkg::CSR_DATA_W-1:0] value);
         case (index)
            tcaf_pkg::CSR_SAMPLE_PERIOD: sample_period = value[15:0];
            tcaf_pkg::CSR_TIME_CONSTANT: time_constant = value;
            tcaf_pkg::CSR_OFFSET_FIRST:  offset_first  = value;
            tcaf_pkg::CSR_OFFSET_SECOND: offset_second = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_angles.size();
      endfunction

      function longint saturate(longint value, output bit clipped);
         clipped = 1'b0;
         if (value > longint'(WORD_MAX)) begin
            clipped = 1'b1;
            return longint'(WORD_MAX);
         end
         if (value < longint'(WORD_MIN)) begin
            clipped = 1'b1;
            return longint'(WORD_MIN);
         end
         return value;
      endfunction

      function longint floor_div(longint num, longint den);
         longint q;
         q = num / den;
         if (num % den != 0 && num < 0)
            q--;
         return q;
      endfunction

      // Coefficient times value, rounded to the value's own scale with ties upward.
      // The value is split so that no product leaves 64 bits.
      function longint scale_by_coef(longint coef, longint value);
         longint low_part;
         low_part = value & (COEF_ONE - 1);
         return coef * (value >>> tcaf_pkg::KBITS)
                + ((coef * low_part + (COEF_ONE >>> 1)) >>> tcaf_pkg::KBITS);
      endfunction

      function void note_sample(logic channel, logic signed [31:0] accel,
                                logic signed [31:0] gyro);
         longint         period, tau, denom, k1, k2, corrected, rate, tau_term, total, angle;
         bit             clipped, ignored;
         angle_beat_type beat;
         period    = sample_period;
         tau       = time_constant;
         rate      = gyro;
         corrected = accel;
         if (channel == 1'b0)
            corrected = corrected + offset_first;
         else
            corrected = corrected - offset_second;
         // The accel clip is silent: it never shows in the saturated field.
         corrected = saturate(corrected, ignored);
         if (!primed[channel]) begin
            last_accel[channel] = corrected;
            last_gyro[channel]  = rate;
            last_angle[channel] = corrected;
            primed[channel]     = 1'b1;
         end
         denom = 2 * tau + period;
         if (denom == 0) begin
            k1 = COEF_ONE;
            k2 = 0;
         end else begin
            k1 = floor_div((2 * tau - period) * COEF_ONE + denom / 2, denom);
            k2 = floor_div(period * COEF_ONE + denom / 2, denom);
         end
         tau_term = (tau * (rate + last_gyro[channel]) + TERM_HALF) >>> tcaf_pkg::FRAC_BITS;
         total    = corrected + last_accel[channel] + tau_term;
         angle    = saturate(scale_by_coef(k1, last_angle[channel]) + scale_by_coef(k2, total),
                             clipped);
         last_accel[channel] = corrected;
         last_gyro[channel]  = rate;
         last_angle[channel] = angle;
         beat.angle     = angle[31:0];
         beat.saturated = clipped;
         expected_angles.push_back(beat);
      endfunction

      function void check_result(logic signed [31:0] angle, logic saturated);
         angle_beat_type want;
         if (expected_angles.size() == 0) begin
            $display("%0t: result beat with nothing outstanding, expected none, actual %0d/%0b",
                     $time, angle, saturated);
            mismatch_count++;
            return;
         end
         want = expected_angles.pop_front();
         if (angle !== want.angle) begin
            $display("%0t: filtered_angle expected %0d actual %0d",
                     $time, want.angle, angle);
            mismatch_count++;
         end
         if (saturated !== want.saturated) begin
            $display("%0t: saturated expected %0b actual %0b",
                     $time, want.saturated, saturated);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset            = 1'b1;
   logic                              req_valid        = 1'b0;
   logic                              req_stall;
   logic                              req_channel      = 1'b0;
   logic signed [31:0]                req_accel_angle  = '0;
   logic signed [31:0]                req_gyro_rate    = '0;
   logic                              rsp_valid;
   logic                              rsp_stall        = 1'b0;
   logic signed [31:0]                rsp_filtered_angle;
   logic                              rsp_saturated;
   logic                              csr_write        = 1'b0;
   logic [tcaf_pkg::CSR_INDEX_W-1:0]  csr_index        = '0;
   logic [tcaf_pkg::CSR_DATA_W-1:0]   csr_data         = '0;

   bit                                long_hold_pending = 1'b0;
   angle_filter_predictor             predictor;

   tustin_complementary_angle_filter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_channel        (req_channel),
      .req_accel_angle    (req_accel_angle),
      .req_gyro_rate      (req_gyro_rate),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_angle (rsp_filtered_angle),
      .rsp_saturated      (rsp_saturated),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         predictor.check_result(rsp_filtered_angle, rsp_saturated);
   end

   // The receiver switches between stall patterns, and on request holds off for a
   // long stretch so that the block backs up into its input.
   initial begin
      flow_mode_type mode;
      int            mode_left;
      int            step;
      mode      = FLOW_FREE;
      mode_left = 0;
      step      = 0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = flow_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            step++;
            case (mode)
               FLOW_FREE:     rsp_stall <= 1'b0;
               FLOW_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < 35);
               FLOW_PERIODIC: rsp_stall <= ((step % 7) < 3);
               default:       rsp_stall <= ($urandom_range(0, 99) < 80);
            endcase
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAIL tustin_complementary_angle_filter");
      $finish;
   end

   function automatic logic signed [31:0] pick_extreme();
      case ($urandom_range(0, 4))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2:       return 32'sd0;
         3:       return 32'sd1;
         default: return -32'sd1;
      endcase
   endfunction

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(0, 4))
         0:       return $urandom;
         1:       return 32'($urandom_range(0, 2097151)) - 32'd1048576;
         2:       return pick_extreme();
         3:       return 32'($urandom_range(0, 134217727)) - 32'd67108864;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_sample(input logic channel, input logic signed [31:0] accel,
                              input logic signed [31:0] gyro);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_channel     <= channel;
      req_accel_angle <= accel;
      req_gyro_rate   <= gyro;
      do @(posedge clock); while (req_stall);
      predictor.note_sample(channel, accel, gyro);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      while (predictor.pending() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [tcaf_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [tcaf_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      predictor.set_register(index, value);
   endtask

   task automatic reprogram(input logic [15:0] period, input logic [23:0] tau,
                            input logic [23:0] first_offset, input logic [23:0] second_offset);
      pause_sender(1);
      wait_drained();
      repeat (3) @(posedge clock);
      write_register(tcaf_pkg::CSR_SAMPLE_PERIOD, tcaf_pkg::CSR_DATA_W'(period));
      write_register(tcaf_pkg::CSR_TIME_CONSTANT, tau);
      write_register(tcaf_pkg::CSR_OFFSET_FIRST,  first_offset);
      write_register(tcaf_pkg::CSR_OFFSET_SECOND, second_offset);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Mostly bursts that look like a sensor: a level with small noise on both fields.
   // The rest is full-range noise and extreme values.
   task automatic run_random(input int count, input int hold_at, input int drain_at);
      int                 burst_left;
      int                 kind;
      bit                 fixed_channel;
      logic               burst_channel;
      logic               channel;
      logic signed [31:0] accel_level, gyro_level, accel, gyro;
      burst_left = 0;
      for (int i = 0; i < count; i++) begin
         if (i == hold_at)
            long_hold_pending = 1'b1;
         if (i == drain_at) begin
            pause_sender(1);
            wait_drained();
         end
         if (burst_left == 0) begin
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
            burst_left    = $urandom_range(1, 16);
            kind          = $urandom_range(0, 9);
            accel_level   = pick_word();
            gyro_level    = pick_word();
            fixed_channel = 1'($urandom_range(0, 1));
            burst_channel = 1'($urandom_range(0, 1));
         end
         burst_left--;
         channel = fixed_channel ? burst_channel : 1'($urandom_range(0, 1));
         if (kind < 6) begin
            accel = accel_level + (32'($urandom_range(0, 4095)) - 32'd2048);
            gyro  = gyro_level + (32'($urandom_range(0, 4095)) - 32'd2048);
         end else if (kind < 8) begin
            accel = $urandom;
            gyro  = $urandom;
         end else begin
            accel = pick_extreme();
            gyro  = pick_extreme();
         end
         send_sample(channel, accel, gyro);
      end
   endtask

   initial begin
      predictor = new();
      wait (!reset);

      // Reset settings: priming of each channel, then the field extremes and the
      // corrected accel angle overflowing both ways.
      send_sample(1'b0, 32'sd123456, -32'sd65536);
      send_sample(1'b1, -32'sd7, 32'sd1);
      send_sample(1'b0, WORD_MAX, 32'sd0);
      send_sample(1'b1, WORD_MIN, 32'sd0);
      send_sample(1'b0, WORD_MIN, WORD_MAX);
      send_sample(1'b1, WORD_MAX, WORD_MIN);
      send_sample(1'b0, 32'sd0, WORD_MIN);
      send_sample(1'b1, -32'sd1, -32'sd1);
      send_sample(1'b0, 32'sd1, 32'sd1);
      run_random(RANDOM_PER_PHASE + 10, 80, 150);

      // Largest period and time constant, then pairs of full-scale beats of each sign on both channels.
      reprogram(16'hFFFF, 24'hFF_FFFF, 24'h7F_FFFF, 24'h80_0000);
      send_sample(1'b0, 32'sd0, WORD_MAX);
      send_sample(1'b0, 32'sd0, WORD_MAX);
      send_sample(1'b0, 32'sd0, WORD_MIN);
      send_sample(1'b0, 32'sd0, WORD_MIN);
      send_sample(1'b1, WORD_MAX, WORD_MAX);
      send_sample(1'b1, WORD_MAX, WORD_MAX);
      send_sample(1'b1, WORD_MIN, WORD_MIN);
      send_sample(1'b1, WORD_MIN, WORD_MIN);
      run_random(RANDOM_PER_PHASE, -1, -1);

      reprogram(16'd1, 24'd1, 24'h80_0000, 24'h7F_FFFF);
      run_random(RANDOM_PER_PHASE, -1, -1);

      // Period far above twice the time constant makes k1 negative.
      reprogram(16'hFFFF, 24'd1, 24'd0, 24'd0);
      run_random(RANDOM_PER_PHASE, -1, -1);

      // Zero denominator: the output holds its previous value.
      reprogram(16'd0, 24'd0, 24'd0, 24'd0);
      send_sample(1'b0, WORD_MAX, WORD_MAX);
      send_sample(1'b1, 32'sd5, -32'sd5);
      run_random(80, -1, -1);

      reprogram(16'($urandom_range(1, 65535)), 24'($urandom_range(1, 16777215)),
                24'($urandom), 24'($urandom));
      run_random(RANDOM_PER_PHASE, 60, -1);

      reprogram(tcaf_pkg::SAMPLE_PERIOD_RESET, tcaf_pkg::TIME_CONSTANT_RESET,
                tcaf_pkg::OFFSET_FIRST_RESET, tcaf_pkg::OFFSET_SECOND_RESET);
      run_random(RANDOM_PER_PHASE, -1, -1);

      pause_sender(1);
      wait_drained();
      repeat (DRAIN_MARGIN) @(posedge clock);
      if (predictor.mismatch_count == 0 && predictor.pending() == 0)
         $display("PASS tustin_complementary_angle_filter");
      else
         $display("FAIL tustin_complementary_angle_filter");
      $finish;
   end

endmodule
